// ----- rtl/mck_pkg.sv -----
// Shared types, constants and the Morse letter table for the keyer.
`default_nettype none

package mck_pkg;

  localparam int unsigned TickW = 16;

  // Character codes that the keyer understands.
  localparam logic [7:0] CODE_A       = 8'd65;
  localparam logic [7:0] CODE_SPACE   = 8'd32;
  localparam logic [7:0] NUM_LETTERS  = 8'd26;

  // Number of letter gaps for a normal letter and for a blank one.
  localparam logic [1:0] GAPS_LETTER  = 2'd1;
  localparam logic [1:0] GAPS_BLANK   = 2'd2;

  // Keyer phase, one-hot.
  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_ON   = 4'b0010,
    PH_EGAP = 4'b0100,
    PH_LGAP = 4'b1000
  } phase_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_DOT_ON     = 2'd0,
    CFG_DASH_ON    = 2'd1,
    CFG_ELEM_GAP   = 2'd2,
    CFG_LETTER_GAP = 2'd3
  } cfg_idx_e;

  localparam logic [TickW-1:0] DOT_ON_RST     = 16'd200;
  localparam logic [TickW-1:0] DASH_ON_RST    = 16'd600;
  localparam logic [TickW-1:0] ELEM_GAP_RST   = 16'd300;
  localparam logic [TickW-1:0] LETTER_GAP_RST = 16'd1400;

  typedef struct packed {
    logic [TickW-1:0] dot_on;
    logic [TickW-1:0] dash_on;
    logic [TickW-1:0] elem_gap;
    logic [TickW-1:0] letter_gap;
  } cfg_t;

  typedef struct packed {
    logic key_level;
    logic busy;
    logic rejected;
    logic done;
  } res_t;

  // Letter table: bits 3..0 are the elements (bit 0 first, 1 = dash),
  // bits 6..4 the element count. Q and V are blank.
  function automatic logic [6:0] morse_entry(input logic [4:0] idx);
    logic [6:0] e;
    case (idx)
      5'd0:    e = 7'h22;
      5'd1:    e = 7'h41;
      5'd2:    e = 7'h45;
      5'd3:    e = 7'h31;
      5'd4:    e = 7'h10;
      5'd5:    e = 7'h44;
      5'd6:    e = 7'h33;
      5'd7:    e = 7'h40;
      5'd8:    e = 7'h20;
      5'd9:    e = 7'h4E;
      5'd10:   e = 7'h35;
      5'd11:   e = 7'h42;
      5'd12:   e = 7'h23;
      5'd13:   e = 7'h21;
      5'd14:   e = 7'h37;
      5'd15:   e = 7'h46;
      5'd16:   e = 7'h00;
      5'd17:   e = 7'h32;
      5'd18:   e = 7'h30;
      5'd19:   e = 7'h11;
      5'd20:   e = 7'h34;
      5'd21:   e = 7'h00;
      5'd22:   e = 7'h36;
      5'd23:   e = 7'h49;
      5'd24:   e = 7'h4D;
      5'd25:   e = 7'h43;
      default: e = 7'h00;
    endcase
    return e;
  endfunction

  // A programmed interval of zero ticks counts as one tick.
  function automatic logic [TickW-1:0] at_least_one(input logic [TickW-1:0] v);
    return (v == '0) ? TickW'(1) : v;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/morse_code_keyer_top.sv -----
// Top level of the tick-driven Morse keyer: request and result registers.
`default_nettype none

// The keyer takes one request per clock cycle: either a time tick or the
// offer of a character. A request lands in an input register; when the
// result register can advance, the keyer state and a result are updated in
// a single pass and written to the result register, so each request
// produces exactly one result, at a sustained rate of one request per cycle
// while the output side keeps taking results. A letter A-Z offered while
// idle is looked up in the Morse table and keyed element by element; a space,
// Q and V key nothing and give two letter gaps. Offers made while busy, and
// codes other than upper-case letters and space, are refused. Interval lengths
// come from four 16-bit registers, each read when its interval starts; a value
// of zero counts as one tick. Write the registers only while no request is
// waiting in the block; a value written in the middle of a character applies
// from the next interval that starts.
module morse_code_keyer_top
  import mck_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // Request channel.
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             req_type_i,
  input  wire logic [7:0]       char_code_i,
  // Result channel.
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic                  key_level_o,
  output logic                  busy_res_o,
  output logic                  char_rejected_o,
  output logic                  char_done_o,
  // Configuration write port.
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_idx_i,
  input  wire logic [TickW-1:0] cfg_wdata_i
);

  cfg_t       cfg;
  res_t       res_next;

  logic       in_vld_q;
  logic       req_q;
  logic [7:0] code_q;
  logic       res_vld_q;
  res_t       res_q;

  logic       advance;
  logic       step;

  // The result register can take a new value when it is empty or being read.
  assign advance    = !res_vld_q || out_ready_i;
  // A held request is processed whenever the result register can advance.
  assign step       = in_vld_q && advance;
  assign in_ready_o = !in_vld_q || advance;

  mck_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  mck_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .req_type_i  (req_q),
    .char_code_i (code_q),
    .cfg_i       (cfg),
    .res_o       (res_next)
  );

  // Input register: valid is control state, the payload needs no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q  <= req_type_i;
      code_q <= char_code_i;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (advance) begin
      res_vld_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_next;
    end
  end

  assign out_valid_o     = res_vld_q;
  assign key_level_o     = res_q.key_level;
  assign busy_res_o      = res_q.busy;
  assign char_rejected_o = res_q.rejected;
  assign char_done_o     = res_q.done;

`ifndef ASSERT_OFF
  // A finished character leaves the keyer idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && char_done_o |-> !busy_res_o)
    else $error("char_done reported while still busy");

  // The key is only ever on while a character is in progress.
  a_key_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && key_level_o |-> busy_res_o)
    else $error("key on while idle");

  // An offer is never both refused and the end of a character.
  a_rej_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(char_rejected_o && char_done_o))
    else $error("rejected and done in one result");

  // Every processed request yields a result in the next cycle.
  a_step_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> res_vld_q)
    else $error("processed request produced no result");
`endif

endmodule

`default_nettype wire

// ----- rtl/mck_cfg.sv -----
// Configuration registers holding the keyer's tick intervals.
`default_nettype none

module mck_cfg
  import mck_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_idx_i,
  input  wire logic [TickW-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DOT_ON:     cfg_d.dot_on     = cfg_wdata_i;
        CFG_DASH_ON:    cfg_d.dash_on    = cfg_wdata_i;
        CFG_ELEM_GAP:   cfg_d.elem_gap   = cfg_wdata_i;
        CFG_LETTER_GAP: cfg_d.letter_gap = cfg_wdata_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dot_on     <= DOT_ON_RST;
      cfg_q.dash_on    <= DASH_ON_RST;
      cfg_q.elem_gap   <= ELEM_GAP_RST;
      cfg_q.letter_gap <= LETTER_GAP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/mck_core.sv -----
// Keyer state registers and the single-pass update for one request.
`default_nettype none

module mck_core
  import mck_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic       req_type_i,
  input  wire logic [7:0] char_code_i,
  input  cfg_t            cfg_i,
  output res_t            res_o
);

  phase_e           phase_q, phase_d;
  logic [3:0]       pat_q, pat_d;
  logic [2:0]       elems_q, elems_d;
  logic [1:0]       gaps_q, gaps_d;
  logic [TickW-1:0] cnt_q, cnt_d;

  logic [7:0]       code_off;
  logic [6:0]       entry;
  logic [3:0]       pat_shift;
  logic [2:0]       elems_dec;
  logic [1:0]       gaps_dec;

  assign code_off  = char_code_i - CODE_A;
  assign entry     = morse_entry(code_off[4:0]);
  assign pat_shift = {1'b0, pat_q[3:1]};
  assign elems_dec = elems_q - 3'd1;
  assign gaps_dec  = gaps_q - 2'd1;

  always_comb begin
    phase_d = phase_q;
    pat_d   = pat_q;
    elems_d = elems_q;
    gaps_d  = gaps_q;
    cnt_d   = cnt_q;
    res_o   = '0;

    if (req_type_i) begin
      if (phase_q != PH_IDLE) begin
        res_o.rejected = 1'b1;
      end else if (char_code_i == CODE_SPACE) begin
        pat_d   = '0;
        elems_d = '0;
        phase_d = PH_LGAP;
        gaps_d  = GAPS_BLANK;
        cnt_d   = at_least_one(cfg_i.letter_gap);
      end else if (char_code_i >= CODE_A && code_off < NUM_LETTERS) begin
        pat_d   = entry[3:0];
        elems_d = entry[6:4];
        if (entry[6:4] == 3'd0) begin
          phase_d = PH_LGAP;
          gaps_d  = GAPS_BLANK;
          cnt_d   = at_least_one(cfg_i.letter_gap);
        end else begin
          phase_d = PH_ON;
          cnt_d   = at_least_one(entry[0] ? cfg_i.dash_on : cfg_i.dot_on);
        end
      end else begin
        res_o.rejected = 1'b1;
      end
      res_o.key_level = (phase_d == PH_ON);
    end else if (phase_q != PH_IDLE) begin
      // The key level reported for a tick is the level during that tick.
      res_o.key_level = (phase_q == PH_ON);
      cnt_d = cnt_q - TickW'(1);
      if (cnt_q == TickW'(1)) begin
        unique case (phase_q)
          PH_ON: begin
            phase_d = PH_EGAP;
            cnt_d   = at_least_one(cfg_i.elem_gap);
          end
          PH_EGAP: begin
            elems_d = elems_dec;
            pat_d   = pat_shift;
            if (elems_dec != 3'd0) begin
              phase_d = PH_ON;
              cnt_d   = at_least_one(pat_shift[0] ? cfg_i.dash_on : cfg_i.dot_on);
            end else begin
              phase_d = PH_LGAP;
              gaps_d  = GAPS_LETTER;
              cnt_d   = at_least_one(cfg_i.letter_gap);
            end
          end
          PH_LGAP: begin
            gaps_d = gaps_dec;
            if (gaps_dec != 2'd0) begin
              cnt_d = at_least_one(cfg_i.letter_gap);
            end else begin
              phase_d    = PH_IDLE;
              pat_d      = '0;
              elems_d    = '0;
              res_o.done = 1'b1;
            end
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end
    end

    res_o.busy = (phase_d != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      pat_q   <= '0;
      elems_q <= '0;
      gaps_q  <= '0;
      cnt_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      pat_q   <= pat_d;
      elems_q <= elems_d;
      gaps_q  <= gaps_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ----- dv/morse_code_keyer_top_test.sv -----
// Self-checking testbench for the Morse keyer: predicts every keying result and checks it.
`default_nettype none

// The keyer takes one request per cycle while its results are taken: a
// time tick, or the offer of a character. Every request gives exactly one
// result, so the testbench keeps its own copy of the keyer state and timing
// registers. On each accepted request it updates that copy and queues the
// result it expects. A checker process compares each accepted result, field
// by field, with the oldest queued result.
//
// The run goes through these tests in turn:
//   - the reset timing: one dot keyed with the registers as they come out of
//     reset, with the letter gap shortened while the dot is still on;
//   - ticks while idle, and codes that are refused (control codes, lower
//     case, the characters just outside A-Z);
//   - zero intervals, which count as one tick, a space, and an offer made while busy;
//   - short letters and a blank letter;
//   - random traffic over many timing settings, under three idling modes;
//   - back-pressure: the receiver stops for a long stretch while the sender
//     keeps offering requests;
//   - the longest intervals that the registers can hold, followed for part
//     of a dot.
// The timing registers are only written once every expected result has come
// back; apart from the reset timing test the keyer is idle then as well.
module morse_code_keyer_top_test;
  import mck_pkg::*;

  localparam longint unsigned CycleLimit = 64'd3_000_000;

  // Morse letters A-Z: bits 3..0 are the elements (bit 0 first, 1 = dash),
  // bits 6..4 the element count. Q and V carry no elements.
  localparam logic [6:0] MorseLetters [0:25] = '{
    7'h22, 7'h41, 7'h45, 7'h31, 7'h10, 7'h44, 7'h33, 7'h40, 7'h20, 7'h4E,
    7'h35, 7'h42, 7'h23, 7'h21, 7'h37, 7'h46, 7'h00, 7'h32, 7'h30, 7'h11,
    7'h34, 7'h00, 7'h36, 7'h49, 7'h4D, 7'h43
  };

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic             req_type_i;
  logic [7:0]       char_code_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic             key_level_o;
  logic             busy_res_o;
  logic             char_rejected_o;
  logic             char_done_o;
  logic             cfg_we_i;
  logic [1:0]       cfg_idx_i;
  logic [TickW-1:0] cfg_wdata_i;

  morse_code_keyer_top u_top (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .req_type_i,
    .char_code_i,
    .out_valid_o,
    .out_ready_i,
    .key_level_o,
    .busy_res_o,
    .char_rejected_o,
    .char_done_o,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i
  );

  // Request kinds on req_type_i.
  localparam bit ReqTick  = 1'b0;
  localparam bit ReqOffer = 1'b1;

  // Keyer state as the testbench expects it to be.
  phase_e           kp_phase;
  logic [3:0]       kp_pattern;
  logic [2:0]       kp_elements;
  logic [1:0]       kp_gaps;
  logic [TickW-1:0] kp_countdown;
  cfg_t             kp_timing;

  res_t             expected_keying [$];
  res_t             oldest_keying;
  int unsigned      mismatches;
  longint unsigned  cycle_count;

  // Idling, in percent of cycles, for each side of the block.
  int unsigned      sender_idle_pct;
  int unsigned      receiver_idle_pct;

  // A test asks for a receiver hold-off by bumping the sequence number; the
  // receiver process then counts the stretch out on its own.
  int unsigned      hold_off_len;
  int unsigned      hold_off_seq;
  int unsigned      hold_off_seen;
  int unsigned      hold_off_left;

  // The clock: period of two time units.
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // A programmed interval of zero ticks lasts one tick.
  function automatic logic [TickW-1:0] nonzero_ticks(input logic [TickW-1:0] v);
    return (v == '0) ? TickW'(1) : v;
  endfunction

  function automatic void begin_element();
    kp_phase     = PH_ON;
    kp_countdown = nonzero_ticks(kp_pattern[0] ? kp_timing.dash_on : kp_timing.dot_on);
  endfunction

  function automatic void begin_letter_gap(input logic [1:0] count);
    kp_phase     = PH_LGAP;
    kp_gaps      = count;
    kp_countdown = nonzero_ticks(kp_timing.letter_gap);
  endfunction

  // Advances the expected keyer state by one request and returns the result
  // that the block has to give for it.
  function automatic res_t keyer_advance(input bit kind, input logic [7:0] code);
    res_t       r;
    logic [6:0] letter;
    r = '0;
    if (kind == ReqOffer) begin
      if (kp_phase != PH_IDLE) begin
        r.rejected = 1'b1;
      end else if (code == CODE_SPACE) begin
        kp_pattern  = '0;
        kp_elements = '0;
        begin_letter_gap(GAPS_BLANK);
      end else if (code >= CODE_A && code < CODE_A + NUM_LETTERS) begin
        letter      = MorseLetters[code - CODE_A];
        kp_pattern  = letter[3:0];
        kp_elements = letter[6:4];
        if (kp_elements == '0) begin
          begin_letter_gap(GAPS_BLANK);
        end else begin
          begin_element();
        end
      end else begin
        r.rejected = 1'b1;
      end
      r.key_level = (kp_phase == PH_ON);
    end else if (kp_phase != PH_IDLE) begin
      // The key level reported for a tick is the one during that tick.
      r.key_level  = (kp_phase == PH_ON);
      kp_countdown = kp_countdown - 1'b1;
      if (kp_countdown == '0) begin
        case (kp_phase)
          PH_ON: begin
            kp_phase     = PH_EGAP;
            kp_countdown = nonzero_ticks(kp_timing.elem_gap);
          end
          PH_EGAP: begin
            kp_elements = kp_elements - 1'b1;
            kp_pattern  = kp_pattern >> 1;
            if (kp_elements != '0) begin
              begin_element();
            end else begin
              begin_letter_gap(GAPS_LETTER);
            end
          end
          default: begin
            kp_gaps = kp_gaps - 1'b1;
            if (kp_gaps != '0) begin
              kp_countdown = nonzero_ticks(kp_timing.letter_gap);
            end else begin
              kp_phase    = PH_IDLE;
              kp_pattern  = '0;
              kp_elements = '0;
              r.done      = 1'b1;
            end
          end
        endcase
      end
    end
    r.busy = (kp_phase != PH_IDLE);
    return r;
  endfunction

  // Sends one request. It starts from the edge at which the previous request
  // was taken and returns at the edge at which this one is taken. Valid is
  // left high on return, so back-to-back requests keep it high throughout.
  task automatic send_request(input bit kind, input logic [7:0] code);
    @(negedge clk_i);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid_i  <= 1'b0;
      req_type_i  <= 1'($urandom_range(1));
      char_code_i <= 8'($urandom_range(255));
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= kind;
    char_code_i <= code;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_keying.push_back(keyer_advance(kind, code));
  endtask

  // Lowers valid and waits until every expected result has come back.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_keying.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Ticks the keyer until the current character is finished.
  task automatic key_until_idle();
    while (kp_phase != PH_IDLE) send_request(ReqTick, 8'($urandom_range(255)));
  endtask

  task automatic write_register(input cfg_idx_e idx, input logic [TickW-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_DOT_ON:   kp_timing.dot_on     = value;
      CFG_DASH_ON:  kp_timing.dash_on    = value;
      CFG_ELEM_GAP: kp_timing.elem_gap   = value;
      default:      kp_timing.letter_gap = value;
    endcase
  endtask

  // Finishes the character in progress, drains the block and then sets all
  // four interval lengths.
  task automatic program_timing(input logic [TickW-1:0] dot, input logic [TickW-1:0] dash,
                                input logic [TickW-1:0] egap, input logic [TickW-1:0] lgap);
    key_until_idle();
    wait_drained();
    write_register(CFG_DOT_ON, dot);
    write_register(CFG_DASH_ON, dash);
    write_register(CFG_ELEM_GAP, egap);
    write_register(CFG_LETTER_GAP, lgap);
  endtask

  // One dot with the timing that comes out of reset. While the dot is still
  // on, the letter gap is shortened: the dot and the element gap keep their
  // reset lengths, and the new letter gap applies once that gap starts.
  task automatic test_reset_timing();
    send_request(ReqOffer, "E");
    repeat (100) send_request(ReqTick, 8'($urandom_range(255)));
    wait_drained();
    write_register(CFG_LETTER_GAP, 16'd5);
    key_until_idle();
    wait_drained();
  endtask

  // Ticks while idle do nothing; codes outside A-Z and space are refused.
  task automatic test_refused_codes();
    send_request(ReqTick, 8'hFF);
    send_request(ReqOffer, 8'h00);
    send_request(ReqOffer, 8'hFF);
    send_request(ReqOffer, "a");
    send_request(ReqOffer, "@");
    send_request(ReqOffer, "[");
    send_request(ReqOffer, 8'(CODE_SPACE + 1'b1));
  endtask

  // Zero intervals last one tick each. The offer made while busy is refused
  // and leaves the letter in progress alone.
  task automatic test_zero_intervals();
    program_timing('0, '0, '0, '0);
    send_request(ReqOffer, "A");
    send_request(ReqOffer, "Z");
    key_until_idle();
    send_request(ReqOffer, CODE_SPACE);
    key_until_idle();
  endtask

  // A dash, a blank letter, and the last letter of the table.
  task automatic test_short_letters();
    program_timing(16'd1, 16'd3, 16'd2, 16'd1);
    send_request(ReqOffer, "T");
    key_until_idle();
    send_request(ReqOffer, "Q");
    key_until_idle();
    send_request(ReqOffer, "Z");
    key_until_idle();
  endtask

  // Random traffic over several short timing settings. Most of it is whole
  // characters ticked through to the end, the rest refused offers.
  task automatic test_random_traffic(input int unsigned settings, input int unsigned per_setting);
    logic [TickW-1:0] ticks [4];
    int unsigned      taken;
    int unsigned      pick;
    for (int unsigned s = 0; s < settings; s++) begin
      for (int k = 0; k < 4; k++) begin
        ticks[k] = ($urandom_range(99) < 70) ? TickW'($urandom_range(4))
                                             : TickW'($urandom_range(24, 5));
      end
      program_timing(ticks[0], ticks[1], ticks[2], ticks[3]);
      taken = 0;
      while (taken < per_setting) begin
        pick = $urandom_range(99);
        if (kp_phase == PH_IDLE) begin
          if (pick < 8) begin
            send_request(ReqOffer, CODE_SPACE);
            taken++;
          end else if (pick < 80) begin
            send_request(ReqOffer, 8'(CODE_A + $urandom_range(25)));
            taken++;
          end else if (pick < 93) begin
            send_request(ReqOffer, 8'($urandom_range(255)));
            taken++;
          end else begin
            // A tick while idle is ignored by the block; it is not counted.
            send_request(ReqTick, 8'($urandom_range(255)));
          end
        end else begin
          if (pick < 8) begin
            send_request(ReqOffer, 8'($urandom_range(255)));
          end else begin
            send_request(ReqTick, 8'($urandom_range(255)));
          end
          taken++;
        end
      end
    end
  endtask

  // The receiver stops for a long stretch while the sender keeps offering
  // requests back to back, so the block fills up and holds off its input.
  // Then the sender waits until every result has come back.
  task automatic test_backpressure();
    int unsigned saved_idle;
    saved_idle = sender_idle_pct;
    program_timing(16'd2, 16'd4, 16'd1, 16'd3);
    sender_idle_pct = 0;
    hold_off_len    = 80;
    hold_off_seq++;
    send_request(ReqOffer, "B");
    repeat (30) send_request(ReqTick, 8'($urandom_range(255)));
    wait_drained();
    key_until_idle();
    wait_drained();
    sender_idle_pct = saved_idle;
  endtask

  // The longest intervals the registers hold, on a single dot. Only the
  // start of the dot is ticked through, so the run ends with the keyer busy.
  task automatic test_longest_intervals();
    program_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(ReqOffer, "E");
    repeat (64) send_request(ReqTick, 8'($urandom_range(255)));
    wait_drained();
  endtask

  // The receiver drives its ready at the falling edge, either counting out a
  // requested hold-off or idling at random.
  always @(negedge clk_i) begin
    if (hold_off_seq != hold_off_seen) begin
      hold_off_seen = hold_off_seq;
      hold_off_left = hold_off_len;
    end
    if (hold_off_left != 0) begin
      hold_off_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  function automatic void compare_field(input string name, input logic expected,
                                        input logic actual);
    if (actual !== expected) begin
      $display("%0t: %s mismatch: expected %0b, actual %0b", $time, name, expected, actual);
      mismatches++;
    end
  endfunction

  // Every result taken is checked against the oldest expected one.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_keying.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual key %0b busy %0b rej %0b done %0b",
                 $time, key_level_o, busy_res_o, char_rejected_o, char_done_o);
        mismatches++;
      end else begin
        oldest_keying = expected_keying.pop_front();
        compare_field("key_level", oldest_keying.key_level, key_level_o);
        compare_field("busy_res", oldest_keying.busy, busy_res_o);
        compare_field("char_rejected", oldest_keying.rejected, char_rejected_o);
        compare_field("char_done", oldest_keying.done, char_done_o);
      end
    end
  end

  // Stops a run that hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timed out with %0d results outstanding", $time, expected_keying.size());
      $display("morse_code_keyer_top regression: fail");
      $finish;
    end
  end

  initial begin
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    req_type_i        = ReqTick;
    char_code_i       = '0;
    out_ready_i       = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = CFG_DOT_ON;
    cfg_wdata_i       = '0;
    mismatches        = 0;
    cycle_count       = 0;
    hold_off_len      = 0;
    hold_off_seq      = 0;
    hold_off_seen     = 0;
    hold_off_left     = 0;
    kp_phase          = PH_IDLE;
    kp_pattern        = '0;
    kp_elements       = '0;
    kp_gaps           = '0;
    kp_countdown      = '0;
    kp_timing         = {DOT_ON_RST, DASH_ON_RST, ELEM_GAP_RST, LETTER_GAP_RST};

    // The sender idles less than the receiver to begin with.
    sender_idle_pct   = 38;
    receiver_idle_pct = 72;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_timing();
    test_refused_codes();
    test_zero_intervals();
    test_short_letters();
    test_random_traffic(5, 70);

    // Now the receiver is the faster side.
    sender_idle_pct   = 72;
    receiver_idle_pct = 38;
    test_random_traffic(5, 70);
    test_backpressure();

    // Full rate on both sides.
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    test_random_traffic(5, 70);
    test_longest_intervals();

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && expected_keying.size() == 0) begin
      $display("morse_code_keyer_top regression: pass");
    end else begin
      $display("morse_code_keyer_top regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/mck_pkg.sv
rtl/mck_cfg.sv
rtl/mck_core.sv
rtl/morse_code_keyer_top.sv
dv/morse_code_keyer_top_test.sv
